FILE: sv/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  HDR_FIRST      = 8'h55;
  localparam logic [7:0]  HDR_SECOND     = 8'h7A;
  localparam int          FRAME_OVERHEAD = 9;
  localparam logic [11:0] PAYLOAD_SAT    = 12'd4087;

  // Byte positions inside a frame that carry fields of their own.
  localparam int POS_HDR_FIRST  = 0;
  localparam int POS_HDR_SECOND = 1;
  localparam int POS_SEQ        = 3;
  localparam int POS_CMD        = 4;
  localparam int POS_LEN_HIGH   = 5;
  localparam int POS_LEN_LOW    = 6;

  typedef enum logic [2:0] {
    FS_OK       = 3'd0,
    FS_SHORT    = 3'd1,
    FS_LEN      = 3'd2,
    FS_HEADER   = 3'd3,
    FS_CRC      = 3'd4,
    FS_OVERFLOW = 3'd5
  } frame_status_t;

endpackage

`default_nettype wire

FILE: sv/sfr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/sfr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_status;
  logic [7:0]  command;
  logic [7:0]  comm_number;
  logic [11:0] payload_length;

  modport source (output valid, output frame_status, output command, output comm_number,
                  output payload_length, input ready);
  modport sink (input valid, input frame_status, input command, input comm_number,
                input payload_length, output ready);
endinterface

`default_nettype wire

FILE: sv/sfr_crc8.sv
`timescale 1ns / 1ps
`default_nettype none

// One byte of CRC-16/MODBUS: eight reflected shift steps, unrolled.
module sfr_crc8 import sfr_pkg::*; (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

FILE: sv/serial_frame_receiver_crc16.sv
// A frame's ending tick is registered in the input stage, its result in the output stage.
// Throughput: one byte or tick transaction per cycle; the frame state is updated by one
// registered step per item, with the byte CRC unrolled into that step.
// A result waiting in the output register stalls only items that would end another frame.
// Reset (rst, synchronous, active high) empties both stages, clears the frame state and
// sets idle_timeout to 5.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver_crc16 import sfr_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst,
  sfr_in_if.sink     rx,
  sfr_out_if.source  result,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SUM_W = 17;

  logic [7:0] idle_timeout;

  // Input stage.
  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;

  // Frame state.
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       idle_ticks, idle_ticks_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [15:0]      trailer_delay, trailer_delay_next;
  logic             header_ok, header_ok_next;
  logic [15:0]      length_field, length_field_next;
  logic [7:0]       seq_byte, seq_byte_next;
  logic [7:0]       cmd_byte, cmd_byte_next;
  logic             overflowed, overflowed_next;

  // Output stage.
  logic          out_valid, out_valid_next;
  frame_status_t out_status;
  logic [7:0]    out_command;
  logic [7:0]    out_comm_number;
  logic [11:0]   out_payload_length;

  logic          frame_done;
  logic          step;
  logic [15:0]   crc_fed;
  frame_status_t status_now;
  logic [11:0]   plen_now;

  sfr_crc8 u_crc8 (
    .crc_in  (running_crc),
    .data    (trailer_delay[15:8]),
    .crc_out (crc_fed)
  );

  assign frame_done = in_action && (byte_count != '0) && (idle_ticks >= idle_timeout);
  // An item that ends a frame needs room in the output register; any other item never waits.
  assign step     = in_valid && (!frame_done || !out_valid || result.ready);
  assign rx.ready = !in_valid || step;

  always_comb begin
    priority if (overflowed) begin
      status_now = FS_OVERFLOW;
    end else if (byte_count < CNT_W'(FRAME_OVERHEAD)) begin
      status_now = FS_SHORT;
    end else if (SUM_W'(byte_count) != (SUM_W'(length_field) + SUM_W'(FRAME_OVERHEAD))) begin
      status_now = FS_LEN;
    end else if (!header_ok) begin
      status_now = FS_HEADER;
    end else if (trailer_delay != running_crc) begin
      status_now = FS_CRC;
    end else begin
      status_now = FS_OK;
    end
    plen_now = (length_field > {4'h0, PAYLOAD_SAT}) ? PAYLOAD_SAT : length_field[11:0];
  end

  always_comb begin
    byte_count_next    = byte_count;
    idle_ticks_next    = idle_ticks;
    running_crc_next   = running_crc;
    trailer_delay_next = trailer_delay;
    header_ok_next     = header_ok;
    length_field_next  = length_field;
    seq_byte_next      = seq_byte;
    cmd_byte_next      = cmd_byte;
    overflowed_next    = overflowed;
    if (step) begin
      if (!in_action) begin
        idle_ticks_next = '0;
        if (byte_count >= CNT_W'(MAX_FRAME_BYTES)) begin
          // The byte is dropped but still counts as activity on the line.
          overflowed_next = 1'b1;
        end else begin
          // The CRC trails the input by two bytes so the trailer stays out of it.
          if (byte_count >= CNT_W'(2)) begin
            running_crc_next = crc_fed;
          end
          trailer_delay_next = {trailer_delay[7:0], in_byte};
          if (byte_count == CNT_W'(POS_HDR_FIRST) && in_byte != HDR_FIRST) begin
            header_ok_next = 1'b0;
          end
          if (byte_count == CNT_W'(POS_HDR_SECOND) && in_byte != HDR_SECOND) begin
            header_ok_next = 1'b0;
          end
          if (byte_count == CNT_W'(POS_SEQ)) begin
            seq_byte_next = in_byte;
          end
          if (byte_count == CNT_W'(POS_CMD)) begin
            cmd_byte_next = in_byte;
          end
          if (byte_count == CNT_W'(POS_LEN_HIGH)) begin
            length_field_next[15:8] = in_byte;
          end
          if (byte_count == CNT_W'(POS_LEN_LOW)) begin
            length_field_next[7:0] = in_byte;
          end
          byte_count_next = byte_count + CNT_W'(1);
        end
      end else if (byte_count != '0) begin
        if (frame_done) begin
          byte_count_next    = '0;
          idle_ticks_next    = '0;
          running_crc_next   = CRC_INIT;
          trailer_delay_next = '0;
          header_ok_next     = 1'b1;
          length_field_next  = '0;
          seq_byte_next      = '0;
          cmd_byte_next      = '0;
          overflowed_next    = 1'b0;
        end else begin
          idle_ticks_next = idle_ticks + 8'd1;
        end
      end
    end
  end

  always_comb begin
    if (step && frame_done) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout  <= 8'd5;
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      byte_count    <= '0;
      idle_ticks    <= '0;
      running_crc   <= CRC_INIT;
      trailer_delay <= '0;
      header_ok     <= 1'b1;
      length_field  <= '0;
      seq_byte      <= '0;
      cmd_byte      <= '0;
      overflowed    <= 1'b0;
    end else begin
      if (cfg_we) begin
        idle_timeout <= cfg_wdata;
      end
      if (rx.ready) begin
        in_valid <= rx.valid;
      end
      out_valid     <= out_valid_next;
      byte_count    <= byte_count_next;
      idle_ticks    <= idle_ticks_next;
      running_crc   <= running_crc_next;
      trailer_delay <= trailer_delay_next;
      header_ok     <= header_ok_next;
      length_field  <= length_field_next;
      seq_byte      <= seq_byte_next;
      cmd_byte      <= cmd_byte_next;
      overflowed    <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_action <= rx.action;
      in_byte   <= rx.rx_byte;
    end
    if (step && frame_done) begin
      out_status         <= status_now;
      out_command        <= cmd_byte;
      out_comm_number    <= seq_byte;
      out_payload_length <= plen_now;
    end
  end

  assign result.valid          = out_valid;
  assign result.frame_status   = out_status;
  assign result.command        = out_command;
  assign result.comm_number    = out_comm_number;
  assign result.payload_length = out_payload_length;

endmodule

`default_nettype wire

FILE: sv/sfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_checker import sfr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  frame_status,
  input wire logic [11:0] payload_length
);

  // A result that is not taken stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result transaction dropped while stalled");

  a_no_res_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_status == FS_OK || frame_status == FS_SHORT ||
                   frame_status == FS_LEN || frame_status == FS_HEADER ||
                   frame_status == FS_CRC || frame_status == FS_OVERFLOW))
    else $error("frame status out of range");

  a_plen_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> payload_length <= PAYLOAD_SAT)
    else $error("payload length above saturation limit");

endmodule

bind serial_frame_receiver_crc16 sfr_checker u_sfr_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .frame_status   (result.frame_status),
  .payload_length (result.payload_length)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sfr_pkg::*;

  localparam int         MAX_BYTES        = 4096;
  localparam logic [7:0] TIMEOUT_AT_RESET = 8'd5;
  localparam int         CYCLE_LIMIT      = 400000;
  localparam int         IDLE_PCT         = 37;

  typedef struct packed {
    frame_status_t status;
    logic [7:0]    command;
    logic [7:0]    comm_number;
    logic [11:0]   payload_length;
  } frame_result_t;

  typedef enum {ROW_BYTE, ROW_TICK, ROW_TRAILER, ROW_TIMEOUT} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [7:0]    data;
    bit            pinned;
    frame_result_t res;
  } script_row_t;

  typedef enum {
    FR_GOOD, FR_BAD_CRC, FR_BAD_HDR, FR_BAD_LEN, FR_SHORT, FR_NOISE, FR_MAX, FR_OVERFLOW
  } frame_kind_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  sfr_in_if  rx_if ();
  sfr_out_if res_if ();

  serial_frame_receiver_crc16 #(
    .MAX_FRAME_BYTES(MAX_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .result(res_if),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the receiver's frame state and of its timeout register.
  int          m_count;
  logic [7:0]  m_idle;
  logic [15:0] m_crc;
  logic [15:0] m_trail;
  bit          m_hdr_ok;
  logic [15:0] m_len;
  logic [7:0]  m_seq;
  logic [7:0]  m_cmd;
  bit          m_ovf;
  logic [7:0]  m_timeout;

  frame_result_t expected_frames[$];

  int            error_count = 0;
  int            cycle_count = 0;
  int            items_sent  = 0;
  bit            calm;
  bit            pin_flag;
  frame_result_t pin_res;
  logic [7:0]    cur_timeout;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic clear_frame_state();
    m_count  = 0;
    m_idle   = 8'd0;
    m_crc    = CRC_INIT;
    m_trail  = 16'd0;
    m_hdr_ok = 1'b1;
    m_len    = 16'd0;
    m_seq    = 8'd0;
    m_cmd    = 8'd0;
    m_ovf    = 1'b0;
  endtask

  task automatic track_item(input logic act, input logic [7:0] b, output bit done,
                            output frame_result_t r);
    done = 1'b0;
    r = '0;
    if (!act) begin
      m_idle = 8'd0;
      if (m_count >= MAX_BYTES) begin
        m_ovf = 1'b1;
      end else begin
        // The last two bytes wait in the trailer delay before they enter the CRC.
        if (m_count >= 2) m_crc = crc16_step(m_crc, m_trail[15:8]);
        m_trail = {m_trail[7:0], b};
        if (m_count == POS_HDR_FIRST && b != HDR_FIRST) m_hdr_ok = 1'b0;
        if (m_count == POS_HDR_SECOND && b != HDR_SECOND) m_hdr_ok = 1'b0;
        if (m_count == POS_SEQ) m_seq = b;
        if (m_count == POS_CMD) m_cmd = b;
        if (m_count == POS_LEN_HIGH) m_len[15:8] = b;
        if (m_count == POS_LEN_LOW) m_len[7:0] = b;
        m_count++;
      end
    end else if (m_count != 0) begin
      if (m_idle < m_timeout) begin
        m_idle++;
      end else begin
        done = 1'b1;
        if (m_ovf) r.status = FS_OVERFLOW;
        else if (m_count < FRAME_OVERHEAD) r.status = FS_SHORT;
        else if (m_count != int'(m_len) + FRAME_OVERHEAD) r.status = FS_LEN;
        else if (!m_hdr_ok) r.status = FS_HEADER;
        else if (m_trail != m_crc) r.status = FS_CRC;
        else r.status = FS_OK;
        r.command        = m_cmd;
        r.comm_number    = m_seq;
        r.payload_length = (m_len > {4'd0, PAYLOAD_SAT}) ? PAYLOAD_SAT : m_len[11:0];
        clear_frame_state();
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : watch
    bit            done;
    frame_result_t r;
    frame_result_t want;
    if (rst) begin
      clear_frame_state();
      m_timeout = TIMEOUT_AT_RESET;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result transaction with no frame pending");
        end else begin
          want = expected_frames.pop_front();
          if (res_if.frame_status !== want.status)
            report_mismatch($sformatf("frame_status %0d, want %0d",
                                      res_if.frame_status, want.status));
          if (res_if.command !== want.command)
            report_mismatch($sformatf("command %0h, want %0h", res_if.command, want.command));
          if (res_if.comm_number !== want.comm_number)
            report_mismatch($sformatf("comm_number %0h, want %0h",
                                      res_if.comm_number, want.comm_number));
          if (res_if.payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length %0d, want %0d",
                                      res_if.payload_length, want.payload_length));
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        track_item(rx_if.action, rx_if.rx_byte, done, r);
        if (pin_flag) expected_frames.push_back(pin_res);
        else if (done) expected_frames.push_back(r);
      end
      if (cfg_we) m_timeout = cfg_wdata;
    end
  end

  always @(negedge clk) begin
    res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_item(input logic act, input logic [7:0] b, input bit pin,
                           input frame_result_t pres);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.action  <= act;
    rx_if.rx_byte <= b;
    pin_flag      <= pin;
    pin_res       <= pres;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b, 1'b0, '0);
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom), 1'b0, '0);
  endtask

  // Enough ticks to end any frame in progress; extra ones are ignored by the block.
  task automatic close_frame();
    repeat (int'(cur_timeout) + 1) send_tick();
  endtask

  task automatic drain_results();
    rx_if.valid <= 1'b0;
    @(negedge clk);
    while (expected_frames.size() != 0) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [7:0] v);
    close_frame();
    drain_results();
    // A tick that only counts idle time leaves no result behind, so give the pipeline time.
    repeat (6) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_timeout = v;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    logic [15:0] lenf;
    int          plen;
    int          n;
    int          pick;
    if (kind == FR_SHORT || kind == FR_NOISE) begin
      n = (kind == FR_SHORT) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      repeat (n) bytes.push_back(8'($urandom));
      if (kind == FR_SHORT && $urandom_range(0, 1)) begin
        bytes[0] = HDR_FIRST;
        if (n > 1) bytes[1] = HDR_SECOND;
      end
    end else begin
      if (kind == FR_MAX || kind == FR_OVERFLOW) plen = PAYLOAD_SAT;
      else if ($urandom_range(0, 9) == 0) plen = $urandom_range(7, 40);
      else plen = $urandom_range(0, 6);
      lenf = 16'(plen);
      if (kind == FR_BAD_LEN) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) lenf = 16'($urandom);
        else if (pick == 1) lenf = 16'(plen + $urandom_range(1, 3));
        else lenf = (plen == 0) ? 16'hFFFF : 16'(plen - 1);
      end
      bytes.push_back(HDR_FIRST);
      bytes.push_back(HDR_SECOND);
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
      bytes.push_back(lenf[15:8]);
      bytes.push_back(lenf[7:0]);
      repeat (plen) bytes.push_back(8'($urandom));
      if (kind == FR_BAD_HDR) begin
        pick = $urandom_range(0, 1);
        bytes[pick] = bytes[pick] ^ 8'(1 << $urandom_range(0, 7));
      end
      crc = CRC_INIT;
      foreach (bytes[i]) crc = crc16_step(crc, bytes[i]);
      bytes.push_back(crc[15:8]);
      bytes.push_back(crc[7:0]);
      if (kind == FR_BAD_CRC) begin
        pick = bytes.size() - 1 - $urandom_range(0, 1);
        bytes[pick] = bytes[pick] ^ 8'(1 << $urandom_range(0, 7));
      end
      if (kind == FR_OVERFLOW) repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
    end
    foreach (bytes[i]) begin
      send_byte(bytes[i]);
      // Silence inside a frame, at most up to the timeout, must not end it.
      if (cur_timeout != 0 && cur_timeout <= 8 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, int'(cur_timeout))) send_tick();
    end
    close_frame();
    repeat ($urandom_range(0, 2)) send_tick();
  endtask

  initial begin : stimulus
    script_row_t script[26];
    logic [15:0] tbl_crc;
    logic [7:0]  settings[6];
    int          phase_start;
    int          frames_in_phase;
    int          pick;
    frame_kind_t kind;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'd0;
    rx_if.valid   = 1'b0;
    rx_if.action  = 1'b0;
    rx_if.rx_byte = 8'd0;
    res_if.ready  = 1'b0;
    calm          = 1'b0;
    pin_flag      = 1'b0;
    pin_res       = '0;
    cur_timeout   = TIMEOUT_AT_RESET;

    script = '{
      // Reset timeout: a lone tick, then one byte that ends on the sixth tick.
      '{ROW_TICK,    8'h00, 1'b0, '0},
      '{ROW_BYTE,    8'h00, 1'b0, '0},
      '{ROW_TICK,    8'h00, 1'b0, '0},
      '{ROW_TICK,    8'h00, 1'b0, '0},
      '{ROW_TICK,    8'h00, 1'b0, '0},
      '{ROW_TICK,    8'h00, 1'b0, '0},
      '{ROW_TICK,    8'h00, 1'b0, '0},
      '{ROW_TICK,    8'h00, 1'b1, '{FS_SHORT, 8'h00, 8'h00, 12'd0}},
      '{ROW_TIMEOUT, 8'h00, 1'b0, '0},
      // Smallest well-formed frame, ended by the first tick.
      '{ROW_BYTE,    8'h55, 1'b0, '0},
      '{ROW_BYTE,    8'h7A, 1'b0, '0},
      '{ROW_BYTE,    8'h00, 1'b0, '0},
      '{ROW_BYTE,    8'hA5, 1'b0, '0},
      '{ROW_BYTE,    8'hFF, 1'b0, '0},
      '{ROW_BYTE,    8'h00, 1'b0, '0},
      '{ROW_BYTE,    8'h00, 1'b0, '0},
      '{ROW_TRAILER, 8'h00, 1'b0, '0},
      '{ROW_TICK,    8'h00, 1'b1, '{FS_OK, 8'hFF, 8'hA5, 12'd0}},
      // All ones, too short, with a length field that saturates.
      '{ROW_BYTE,    8'hFF, 1'b0, '0},
      '{ROW_BYTE,    8'hFF, 1'b0, '0},
      '{ROW_BYTE,    8'hFF, 1'b0, '0},
      '{ROW_BYTE,    8'hFF, 1'b0, '0},
      '{ROW_BYTE,    8'hFF, 1'b0, '0},
      '{ROW_BYTE,    8'hFF, 1'b0, '0},
      '{ROW_BYTE,    8'hFF, 1'b0, '0},
      '{ROW_TICK,    8'h00, 1'b1, '{FS_SHORT, 8'hFF, 8'hFF, PAYLOAD_SAT}}
    };

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tbl_crc = CRC_INIT;
    foreach (script[i]) begin
      case (script[i].kind)
        ROW_BYTE: begin
          send_item(1'b0, script[i].data, script[i].pinned, script[i].res);
          tbl_crc = crc16_step(tbl_crc, script[i].data);
        end
        ROW_TICK: begin
          send_item(1'b1, script[i].data, script[i].pinned, script[i].res);
          tbl_crc = CRC_INIT;
        end
        ROW_TRAILER: begin
          send_byte(tbl_crc[15:8]);
          send_byte(tbl_crc[7:0]);
        end
        ROW_TIMEOUT: begin
          set_timeout(script[i].data);
          tbl_crc = CRC_INIT;
        end
      endcase
    end

    settings = '{8'd0, 8'd2, 8'd255, 8'd1, 8'($urandom_range(3, 9)), TIMEOUT_AT_RESET};
    foreach (settings[p]) begin
      set_timeout(settings[p]);
      calm = (p == 3);
      if (p == 3) begin
        send_frame(FR_MAX);
        send_frame(FR_OVERFLOW);
      end
      phase_start = items_sent;
      frames_in_phase = 0;
      while (items_sent - phase_start < ((settings[p] == 8'd255) ? 300 : 70)) begin
        pick = $urandom_range(0, 99);
        kind = (pick < 55) ? FR_GOOD :
               (pick < 63) ? FR_BAD_CRC :
               (pick < 71) ? FR_BAD_HDR :
               (pick < 80) ? FR_BAD_LEN :
               (pick < 90) ? FR_SHORT : FR_NOISE;
        send_frame(kind);
        if (p == 1 && (frames_in_phase == 0 || $urandom_range(0, 3) == 0)) drain_results();
        frames_in_phase++;
      end
      calm = 1'b0;
    end

    close_frame();
    drain_results();
    repeat (10) @(negedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
